[design/frame_allocator_lru_victim_macros.svh]
// Assertion macros used by the frame allocator datapath.
`ifndef FRAME_ALLOCATOR_LRU_VICTIM_MACROS_SVH
`define FRAME_ALLOCATOR_LRU_VICTIM_MACROS_SVH

// Checked only outside reset.
`define FALV_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("frame allocator assertion failed");

// Checked at every edge, reset included.
`define FALV_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("frame allocator assertion failed");

`endif

[design/falv_pkg.sv]
// Shared types and codes of the frame allocator.
package falv_pkg;

   localparam logic [2:0] REQ_ALLOC = 3'd0;
   localparam logic [2:0] REQ_FREE  = 3'd1;
   localparam logic [2:0] REQ_TOUCH = 3'd2;
   localparam logic [2:0] REQ_DIRTY = 3'd3;
   localparam logic [2:0] REQ_QUERY = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFRAME = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   typedef struct packed {
      logic        used;
      logic [7:0]  owner;
      logic [15:0] page;
      logic [31:0] stamp;
      logic        dirty;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic out_busy;
   } sts_type;

endpackage

[design/falv_ctrl.sv]
// Sequencer of the frame allocator: clearing pass, table scan and commit.
module falv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  falv_pkg::sts_type sts,
   output falv_pkg::cmd_type cmd
);
   import falv_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.idx_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

[design/falv_dpath.sv]
// Frame table memory, scan trackers, update logic and result register.
`include "frame_allocator_lru_victim_macros.svh"

module falv_dpath #(
   parameter int NUM_FRAMES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  falv_pkg::cmd_type cmd,
   output falv_pkg::sts_type sts,
   input  logic [2:0]        req_tuser,
   input  logic [63:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        rsp_tuser,
   output logic [47:0]       rsp_tdata
);
   import falv_pkg::*;

   localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW = $clog2(NUM_FRAMES + 1);

   entry_type mem_ff [NUM_FRAMES];
   entry_type rdata_ff;

   logic [2:0]    req_type_ff;
   logic [7:0]    owner_ff;
   logic [15:0]   page_ff;
   logic [5:0]    sel_ff;
   logic [31:0]   now_ff;

   logic [AW-1:0] rd_idx_ff;
   logic          d_vld_ff;
   logic [AW-1:0] d_idx_ff;

   logic          ff_found_ff;
   logic [AW-1:0] ff_idx_ff;
   logic          ff_rused_ff;
   logic          sel_lused_ff;
   logic          sel_rused_ff;
   entry_type     sel_ent_ff;
   logic          cl_found_ff;
   logic [AW-1:0] cl_idx_ff;
   entry_type     cl_ent_ff;
   logic          dt_found_ff;
   logic [AW-1:0] dt_idx_ff;
   entry_type     dt_ent_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] runs_ff, runs_in;

   logic          out_vld_ff;
   logic [1:0]    out_status_ff;
   logic [47:0]   out_data_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          upd_en;
   logic [AW-1:0] upd_addr;
   entry_type     upd_data;
   logic [1:0]    status;
   logic [5:0]    frame_out;
   logic          did_evict;
   entry_type     vic_ent;
   logic          sel_alloc;
   logic          sel_ok;
   logic          eligible;
   logic [31:0]   j32;
   logic [31:0]   s32;
   logic [CW:0]   runs_sum;

   assign sts.idx_last = (rd_idx_ff == AW'(NUM_FRAMES - 1));
   assign sts.out_busy = out_vld_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_type_ff <= req_tuser;
         owner_ff    <= req_tdata[7:0];
         page_ff     <= req_tdata[23:8];
         sel_ff      <= req_tdata[29:24];
         now_ff      <= req_tdata[61:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         d_vld_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            rd_idx_ff <= '0;
         end else if (cmd.issue || cmd.clear) begin
            rd_idx_ff <= rd_idx_ff + AW'(1);
         end
         d_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      d_idx_ff <= rd_idx_ff;
      rdata_ff <= mem_ff[rd_idx_ff];
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   assign j32      = 32'(d_idx_ff);
   assign s32      = 32'(sel_ff);
   assign eligible = rdata_ff.used && (rdata_ff.owner != 8'd0);

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         ff_found_ff  <= 1'b0;
         ff_rused_ff  <= 1'b1;
         sel_lused_ff <= 1'b1;
         sel_rused_ff <= 1'b1;
         cl_found_ff  <= 1'b0;
         dt_found_ff  <= 1'b0;
      end else if (d_vld_ff) begin
         if (!rdata_ff.used && !ff_found_ff) begin
            ff_found_ff <= 1'b1;
            ff_idx_ff   <= d_idx_ff;
         end
         if (ff_found_ff && (j32 == 32'(ff_idx_ff) + 32'd1)) ff_rused_ff <= rdata_ff.used;
         if (j32 + 32'd1 == s32) sel_lused_ff <= rdata_ff.used;
         if (j32 == s32) sel_ent_ff <= rdata_ff;
         if (j32 == s32 + 32'd1) sel_rused_ff <= rdata_ff.used;
         if (eligible && !rdata_ff.dirty &&
             (!cl_found_ff || (rdata_ff.stamp < cl_ent_ff.stamp))) begin
            cl_found_ff <= 1'b1;
            cl_idx_ff   <= d_idx_ff;
            cl_ent_ff   <= rdata_ff;
         end
         if (eligible && rdata_ff.dirty &&
             (!dt_found_ff || (rdata_ff.stamp < dt_ent_ff.stamp))) begin
            dt_found_ff <= 1'b1;
            dt_idx_ff   <= d_idx_ff;
            dt_ent_ff   <= rdata_ff;
         end
      end
   end

   always_comb begin
      sel_ok    = (s32 < 32'(NUM_FRAMES));
      upd_en    = 1'b0;
      upd_addr  = AW'(sel_ff);
      upd_data  = sel_ent_ff;
      status    = ST_IGNORED;
      frame_out = '0;
      did_evict = 1'b0;
      vic_ent   = '0;
      sel_alloc = 1'b0;
      cnt_in    = cnt_ff;
      runs_in   = runs_ff;
      runs_sum  = {1'b0, runs_ff} + (CW + 1)'(sel_lused_ff) + (CW + 1)'(sel_rused_ff)
                  - (CW + 1)'(1);
      case (req_type_ff)
         REQ_ALLOC: begin
            upd_data = '{used: 1'b1, owner: owner_ff, page: page_ff,
                         stamp: now_ff, dirty: 1'b0};
            if (ff_found_ff) begin
               upd_en    = 1'b1;
               upd_addr  = ff_idx_ff;
               status    = ST_OK;
               frame_out = 6'(ff_idx_ff);
               cnt_in    = cnt_ff - CW'(1);
               runs_in   = runs_ff - CW'(ff_rused_ff);
            end else if (cl_found_ff || dt_found_ff) begin
               upd_en    = 1'b1;
               upd_addr  = cl_found_ff ? cl_idx_ff : dt_idx_ff;
               vic_ent   = cl_found_ff ? cl_ent_ff : dt_ent_ff;
               status    = ST_OK;
               frame_out = 6'(upd_addr);
               did_evict = 1'b1;
            end else begin
               status = ST_NOFRAME;
            end
         end
         REQ_FREE: begin
            if (sel_ok && sel_ent_ff.used) begin
               upd_en   = 1'b1;
               upd_data = '{used: 1'b0, owner: 8'd0, page: 16'd0,
                            stamp: sel_ent_ff.stamp, dirty: 1'b0};
               status   = ST_OK;
               cnt_in   = cnt_ff + CW'(1);
               runs_in  = CW'(runs_sum);
            end
         end
         REQ_TOUCH: begin
            if (sel_ok && sel_ent_ff.used) begin
               upd_en         = 1'b1;
               upd_data.stamp = now_ff;
               status         = ST_OK;
            end
         end
         REQ_DIRTY: begin
            if (sel_ok && sel_ent_ff.used) begin
               upd_en         = 1'b1;
               upd_data.dirty = 1'b1;
               status         = ST_OK;
            end
         end
         REQ_QUERY: begin
            if (sel_ok) begin
               sel_alloc = sel_ent_ff.used;
               status    = sel_ent_ff.used ? ST_OK : ST_IGNORED;
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase
   end

   assign wr_en   = cmd.clear || (cmd.commit && upd_en);
   assign wr_addr = cmd.clear ? rd_idx_ff : upd_addr;
   assign wr_data = cmd.clear ? entry_type'('0) : upd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= CW'(NUM_FRAMES);
         runs_ff    <= CW'(1);
         out_vld_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            cnt_ff     <= cnt_in;
            runs_ff    <= runs_in;
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= status;
         out_data_ff   <= {2'b00, 6'(runs_in), 7'(cnt_in), sel_alloc, vic_ent.dirty,
                           vic_ent.page, vic_ent.owner, did_evict, frame_out};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = out_data_ff;

   `FALV_ASSERT(a_cnt_bound, cnt_ff <= CW'(NUM_FRAMES))
   `FALV_ASSERT(a_runs_bound, runs_ff <= cnt_ff)
   `FALV_ASSERT(a_commit_free, cmd.commit |-> !(out_vld_ff && !rsp_tready))
   `FALV_ASSERT_ALWAYS(a_no_scan_clear, !(cmd.clear && (cmd.issue || cmd.commit)))

endmodule

[design/frame_allocator_lru_victim.sv]
// Top level of the frame allocator with clean-first LRU victim selection.
// After reset the frame table is cleared entry by entry, during which no item
// is accepted. Every request then goes from acceptance in the idle state to a
// registered result through a scan that reads one table entry per cycle through
// the single read port, the drain state and the commit state, which is held
// while the previous result still waits in the output register. The next item
// is accepted in the cycle after commit.
module frame_allocator_lru_victim #(
   parameter int NUM_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type
   input  logic [2:0]  req_tuser,
   // owner_id[7:0], virt_page[23:8], frame_sel[29:24], now_time[61:30]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status
   output logic [1:0]  rsp_tuser,
   // frame_out[5:0], did_evict[6], evicted_owner[14:7], evicted_page[30:15],
   // evicted_dirty[31], sel_allocated[32], free_total[39:33], free_runs[45:40]
   output logic [47:0] rsp_tdata
);
   import falv_pkg::*;

   cmd_type cmd;
   sts_type sts;

   falv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   falv_dpath #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[test/frame_allocator_checker.sv]
// Checker that models the frame table and compares every response item with its prediction.
module frame_allocator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [1:0]  rsp_tuser,
   input  logic [47:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   import falv_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] data;
   } reply_type;

   entry_type frames [64];
   int        frees_left;
   reply_type expected_replies [$];

   function automatic int find_victim(bit want_clean);
      int       best;
      bit [32:0] oldest;
      best = -1;
      oldest = 33'h1_0000_0000;
      for (int i = 0; i < 64; i++) begin
         if (!frames[i].used || frames[i].owner == 8'd0) continue;
         if (want_clean && frames[i].dirty) continue;
         if ({1'b0, frames[i].stamp} < oldest) begin
            oldest = {1'b0, frames[i].stamp};
            best = i;
         end
      end
      return best;
   endfunction

   function automatic reply_type serve_request(logic [2:0] kind, logic [63:0] d);
      reply_type  r;
      logic [7:0] owner;
      logic [15:0] page;
      logic [5:0] sel;
      logic [31:0] now;
      int         f;
      int         runs;
      bit         in_run;
      logic [5:0] frame_out;
      logic       evict, ev_dirty, sel_alloc;
      logic [7:0] ev_owner;
      logic [15:0] ev_page;
      owner = d[7:0];
      page = d[23:8];
      sel = d[29:24];
      now = d[61:30];
      r.status = ST_IGNORED;
      frame_out = '0;
      evict = 0;
      ev_owner = '0;
      ev_page = '0;
      ev_dirty = 0;
      sel_alloc = 0;
      f = -1;
      if (kind == REQ_ALLOC) begin
         for (int i = 0; i < 64; i++) begin
            if (!frames[i].used) begin
               f = i;
               break;
            end
         end
         if (f >= 0) begin
            frees_left--;
         end else begin
            f = find_victim(1);
            if (f < 0) f = find_victim(0);
            if (f >= 0) begin
               evict = 1;
               ev_owner = frames[f].owner;
               ev_page = frames[f].page;
               ev_dirty = frames[f].dirty;
            end
         end
         if (f < 0) begin
            r.status = ST_NOFRAME;
         end else begin
            frames[f] = '{used: 1'b1, owner: owner, page: page, stamp: now, dirty: 1'b0};
            r.status = ST_OK;
            frame_out = f[5:0];
         end
      end else if (kind == REQ_QUERY) begin
         sel_alloc = frames[sel].used;
         r.status = frames[sel].used ? ST_OK : ST_IGNORED;
      end else if (kind inside {REQ_FREE, REQ_TOUCH, REQ_DIRTY} && frames[sel].used) begin
         r.status = ST_OK;
         if (kind == REQ_FREE) begin
            frames[sel].used = 0;
            frames[sel].owner = '0;
            frames[sel].page = '0;
            frames[sel].dirty = 0;
            frees_left++;
         end else if (kind == REQ_TOUCH) begin
            frames[sel].stamp = now;
         end else begin
            frames[sel].dirty = 1;
         end
      end
      runs = 0;
      in_run = 0;
      for (int i = 0; i < 64; i++) begin
         if (!frames[i].used) begin
            if (!in_run) runs++;
            in_run = 1;
         end else begin
            in_run = 0;
         end
      end
      r.data = {2'b0, runs[5:0], frees_left[6:0], sel_alloc, ev_dirty, ev_page, ev_owner,
                evict, frame_out};
      return r;
   endfunction

   assign pending = expected_replies.size();

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < 64; i++) frames[i] = '0;
         frees_left = 64;
         fail_count <= 0;
         expected_replies.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_replies.push_back(serve_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               if (fail_count < 10) $display("unexpected response item %h %h", rsp_tuser, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_replies.pop_front();
               if (want.status !== rsp_tuser || want.data[45:0] !== rsp_tdata[45:0]) begin
                  if (fail_count < 10)
                     $display("mismatch: expected status %0d data %h, got status %0d data %h",
                              want.status, want.data[45:0], rsp_tuser, rsp_tdata[45:0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[test/testbench.sv]
// Top of the frame allocator test: stimulus, idling and the final verdict.
module testbench;
   import falv_pkg::*;

   localparam int WATCHDOG = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [1:0]  rsp_tuser;
   logic [47:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   bit          calm = 0;

   always #5 clock = ~clock;

   frame_allocator_lru_victim u_dut (.*);

   frame_allocator_checker u_checker (.*);

   // Sink side stalls in random bursts until the calm tail of the run.
   always @(posedge clock) begin
      int burst;
      if (!reset && !calm && $urandom_range(0, 9) == 0) begin
         burst = $urandom_range(1, 18);
         rsp_tready <= 0;
         repeat (burst) @(posedge clock);
      end
      rsp_tready <= 1;
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready || rsp_tvalid && rsp_tready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The valid line stays high after an accept until the next item is driven or the
   // sender idles, so it is driven only once per time step.
   task automatic send_request(logic [2:0] kind, logic [7:0] owner, logic [15:0] page,
                               logic [5:0] sel, logic [31:0] now);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {2'b0, now, sel, page, owner};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_replies();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_request(int fill_bias);
      logic [2:0] kind;
      int         r;
      r = $urandom_range(0, 99);
      if (r < fill_bias) kind = REQ_ALLOC;
      else if (r < 95) kind = 3'($urandom_range(1, 4));
      else kind = 3'($urandom_range(5, 7));
      send_request(kind, ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom),
                   16'($urandom), 6'($urandom), $urandom);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      // Directed: extremes, every request kind, unknown kinds, pinned-only table.
      send_request(REQ_QUERY, 8'd0, 16'd0, 6'd0, 32'd0);
      send_request(REQ_FREE, 8'd0, 16'd0, 6'd63, 32'd0);
      send_request(REQ_TOUCH, 8'd0, 16'd0, 6'd5, 32'd0);
      send_request(REQ_DIRTY, 8'd0, 16'd0, 6'd5, 32'd0);
      send_request(3'd5, 8'hFF, 16'hFFFF, 6'd63, 32'hFFFF_FFFF);
      send_request(3'd7, 8'hFF, 16'hFFFF, 6'd63, 32'hFFFF_FFFF);
      for (int i = 0; i < 64; i++)
         send_request(REQ_ALLOC, 8'd0, 16'(i), 6'd0, 32'(i));
      send_request(REQ_ALLOC, 8'hFF, 16'hFFFF, 6'd0, 32'hFFFF_FFFF);
      send_request(REQ_QUERY, 8'd0, 16'd0, 6'd63, 32'd0);
      send_request(REQ_FREE, 8'd0, 16'd0, 6'd63, 32'd0);
      send_request(REQ_FREE, 8'd0, 16'd0, 6'd10, 32'd0);
      send_request(REQ_ALLOC, 8'hFF, 16'hFFFF, 6'd0, 32'hFFFF_FFFF);
      send_request(REQ_DIRTY, 8'd0, 16'd0, 6'd10, 32'd0);
      send_request(REQ_ALLOC, 8'h01, 16'h1234, 6'd0, 32'd0);
      send_request(REQ_ALLOC, 8'h02, 16'h0001, 6'd0, 32'd7);
      send_request(REQ_TOUCH, 8'd0, 16'd0, 6'd63, 32'hFFFF_FFFF);
      drain_replies();
      // Free everything, then run random phases that alternate filling and churn.
      for (int i = 0; i < 64; i++) send_request(REQ_FREE, 8'd0, 16'd0, 6'(i), 32'd0);
      for (int n = 0; n < 1400; n++) random_request((n / 200) % 2 ? 70 : 35);
      drain_replies();
      calm = 1;
      for (int n = 0; n < 80; n++) random_request(50);
      drain_replies();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/falv_pkg.sv
design/falv_ctrl.sv
design/falv_dpath.sv
design/frame_allocator_lru_victim.sv
test/frame_allocator_checker.sv
test/testbench.sv
